// ===== hw/rtl/dasq_pkg.sv =====
`default_nettype none

package dasq_pkg;

   // Pulse channels
   localparam int PULSE_W = 12;

   // Speed mapping, pulse range and activation length
   localparam longint PULSE_MIN        = 1000;
   localparam longint PULSE_MAX        = 2000;
   localparam longint SPEED_MAX        = 1000;
   localparam longint ACTIVATION_TICKS = 20;

   // Field widths
   localparam int HOLD_W      = 16;
   localparam int THRESH_W    = 12;
   localparam int SPEED_CFG_W = 10;
   localparam int LEVEL_W     = 10;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_DISARMED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PREARMED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARMED    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PREARM_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREARM_HOLD_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_ON_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_OFF_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_HOLD_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CUT_LIMIT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_UP_STEP      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_DOWN_STEP    = 3'd7;

   // Mapping by reciprocal: floor(mag * SPEED_MAX / den) is
   // (mag * MAP_RECIP) >> MAP_SHIFT, exact for every 12-bit magnitude.
   localparam longint MAP_DEN      = PULSE_MAX - PULSE_MIN;
   localparam bit     MAP_DEN_NEG  = (MAP_DEN < 0);
   localparam bit     MAP_DEN_ZERO = (MAP_DEN == 0);
   localparam longint MAP_DEN_ABS  = MAP_DEN_NEG ? -MAP_DEN : (MAP_DEN_ZERO ? 1 : MAP_DEN);
   localparam int     MAP_SHIFT    = PULSE_W + $clog2(MAP_DEN_ABS);
   localparam longint MAP_RECIP    =
      ((SPEED_MAX << MAP_SHIFT) + MAP_DEN_ABS - 1) / MAP_DEN_ABS;
   localparam int     RECIP_W      = $clog2(MAP_RECIP + 1);
   localparam longint PULSE_TOP    = (longint'(1) << PULSE_W) - 1;
   localparam longint MAG_MAX      =
      (PULSE_MIN > PULSE_TOP - PULSE_MIN) ? PULSE_MIN : (PULSE_TOP - PULSE_MIN);
   localparam longint MAP_QMAX     = (MAG_MAX * SPEED_MAX) / MAP_DEN_ABS;
   localparam int     MAP_W        = $clog2(MAP_QMAX + 1) + 2;
   localparam int     PROD_W       = (PULSE_W + RECIP_W > MAP_SHIFT + MAP_W) ?
                                     (PULSE_W + RECIP_W) : (MAP_SHIFT + MAP_W);

   // Drive and compare widths
   localparam int SPEED_BITS = $clog2(SPEED_MAX + 1);
   localparam int DRIVE_W    = (SPEED_BITS > 11) ? SPEED_BITS : 11;
   localparam int CMP_A      = (MAP_W > SPEED_BITS + 1) ? MAP_W : (SPEED_BITS + 1);
   localparam int CMP_W      = (CMP_A > SPEED_CFG_W + 1) ? CMP_A : (SPEED_CFG_W + 1);

   typedef struct packed {
      logic [PULSE_W-1:0] speed_pulse;
      logic [PULSE_W-1:0] arm_pulse;
      logic [PULSE_W-1:0] prearm_pulse;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] drive_level;
      logic               drive_updated;
      logic [MODE_W-1:0]  mode_now;
      logic               activation_line;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dasq_speed_map.sv =====
`default_nettype none

module dasq_speed_map (
   input  wire logic [dasq_pkg::PULSE_W-1:0]     pulse,
   output logic signed [dasq_pkg::MAP_W-1:0]     mapped
);

   logic signed [dasq_pkg::PULSE_W:0]   offset;
   logic [dasq_pkg::PULSE_W-1:0]        mag;
   logic [dasq_pkg::PROD_W-1:0]         prod;
   logic [dasq_pkg::PROD_W-1:0]         prod_shift;
   logic signed [dasq_pkg::MAP_W-1:0]   quot;
   logic                                negate;

   always_comb begin
      offset = $signed({1'b0, pulse})
             - $signed({1'b0, dasq_pkg::PULSE_W'(dasq_pkg::PULSE_MIN)});
      mag    = offset[dasq_pkg::PULSE_W] ? dasq_pkg::PULSE_W'(-offset)
                                         : dasq_pkg::PULSE_W'(offset);
      // keep the reciprocal positive: its top bit is a magnitude bit
      prod   = dasq_pkg::PROD_W'(mag)
             * dasq_pkg::PROD_W'(dasq_pkg::MAP_RECIP);
      prod_shift = prod >> dasq_pkg::MAP_SHIFT;
      quot   = $signed({1'b0, prod_shift[dasq_pkg::MAP_W-2:0]});
      // truncate toward zero: divide magnitudes, then apply the sign
      negate = offset[dasq_pkg::PULSE_W] ^ dasq_pkg::MAP_DEN_NEG;
      if (dasq_pkg::MAP_DEN_ZERO) begin
         mapped = '0;
      end else if (negate) begin
         mapped = -quot;
      end else begin
         mapped = quot;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/debounced_arming_sequencer_core.sv =====
`default_nettype none

// Debounced arming sequencer.
// req_* carries one control tick: speed, arm and prearm pulse widths in
// microseconds. rsp_* returns one transaction per request: the ramped drive
// level, whether the ramp ran, the arming mode and the activation line.
// csr_* writes one of eight tuning registers per clock with csr_we high;
// write only while no request is in flight.
// The request passes through three registers before its response is valid
// (input register, speed-map register, result register). One request per
// cycle is sustained while rsp_ready is high; the single multiplier in the
// speed map sits alone between the input and speed-map registers, and the
// debounce, mode and ramp update sits alone before the result register.
// A stalled rsp_ready holds the result register and lets earlier stages
// fill behind it; req_ready drops once all three stages are full.
// Reset (synchronous, active high) empties the pipeline, returns to the
// disarmed mode with zero drive, clears all debounce counters and reloads
// the registers with their default values.

module debounced_arming_sequencer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire dasq_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dasq_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [dasq_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [dasq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW = dasq_pkg::DRIVE_W;
   localparam int HW = dasq_pkg::HOLD_W;
   localparam int TW = dasq_pkg::THRESH_W;
   localparam int SW = dasq_pkg::SPEED_CFG_W;

   // Tuning registers
   logic [TW-1:0] prearm_threshold_ff;
   logic [HW-1:0] prearm_hold_ticks_ff;
   logic [TW-1:0] arm_on_threshold_ff;
   logic [TW-1:0] arm_off_threshold_ff;
   logic [HW-1:0] arm_hold_ticks_ff;
   logic [SW-1:0] speed_cut_limit_ff;
   logic [SW-1:0] ramp_up_step_ff;
   logic [SW-1:0] ramp_down_step_ff;

   // Pipeline
   logic                                 s1_valid_ff;
   dasq_pkg::req_type                    s1_data_ff;
   logic                                 s2_valid_ff;
   logic signed [dasq_pkg::MAP_W-1:0]    s2_mapped_ff;
   logic [dasq_pkg::PULSE_W-1:0]         s2_arm_pulse_ff;
   logic [dasq_pkg::PULSE_W-1:0]         s2_prearm_pulse_ff;
   logic                                 out_valid_ff;
   dasq_pkg::rsp_type                    out_data_ff;
   logic signed [dasq_pkg::MAP_W-1:0]    mapped;

   logic out_take, s2_take, s2_fire, s1_take;

   // Sequencer state
   logic [dasq_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic                        prearm_on_ff, prearm_on_in;
   logic                        arm_on_ff, arm_on_in;
   logic [HW-1:0]               prearm_on_cnt_ff, prearm_on_cnt_in;
   logic [HW-1:0]               prearm_off_cnt_ff, prearm_off_cnt_in;
   logic [HW-1:0]               arm_on_cnt_ff, arm_on_cnt_in;
   logic [HW-1:0]               arm_off_cnt_ff, arm_off_cnt_in;
   logic [HW-1:0]               ticks_left_ff, ticks_left_in;
   logic [DW-1:0]               drive_ff, drive_in;
   logic                        act_ff, act_in;
   logic                        updated;
   logic                        run_arm;

   logic signed [dasq_pkg::CMP_W-1:0] mapped_x;
   logic signed [dasq_pkg::CMP_W-1:0] cut_x;
   logic                              below_cut;
   logic [DW-1:0]                     setpoint;

   // Step the drive toward target; never pass it.
   function automatic logic [DW-1:0] ramp_to(
      input logic [DW-1:0] target,
      input logic [DW-1:0] drive,
      input logic [SW-1:0] up_step,
      input logic [SW-1:0] down_step
   );
      logic [DW-1:0] result;
      result = drive;
      if (target > drive) begin
         if (target - drive <= DW'(up_step)) begin
            result = target;
         end else begin
            result = drive + DW'(up_step);
         end
      end else if (target < drive) begin
         if (drive - target <= DW'(down_step)) begin
            result = target;
         end else begin
            result = drive - DW'(down_step);
         end
      end
      return result;
   endfunction

   // Handshake: each stage advances when the next is empty or moving.
   assign out_take  = !out_valid_ff || rsp_ready;
   assign s2_fire   = s2_valid_ff && out_take;
   assign s2_take   = !s2_valid_ff || out_take;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign req_ready = s1_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Map the speed pulse onto 0..SPEED_MAX (may fall outside that range).
   dasq_speed_map u_speed_map (
      .pulse  (s1_data_ff.speed_pulse),
      .mapped (mapped)
   );

   // Tuning register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prearm_threshold_ff  <= TW'(1500);
         prearm_hold_ticks_ff <= HW'(10);
         arm_on_threshold_ff  <= TW'(1700);
         arm_off_threshold_ff <= TW'(1300);
         arm_hold_ticks_ff    <= HW'(10);
         speed_cut_limit_ff   <= SW'(50);
         ramp_up_step_ff      <= SW'(5);
         ramp_down_step_ff    <= SW'(10);
      end else if (csr_we) begin
         case (csr_addr)
            dasq_pkg::CSR_PREARM_THRESHOLD:  prearm_threshold_ff  <= csr_wdata[TW-1:0];
            dasq_pkg::CSR_PREARM_HOLD_TICKS: prearm_hold_ticks_ff <= csr_wdata[HW-1:0];
            dasq_pkg::CSR_ARM_ON_THRESHOLD:  arm_on_threshold_ff  <= csr_wdata[TW-1:0];
            dasq_pkg::CSR_ARM_OFF_THRESHOLD: arm_off_threshold_ff <= csr_wdata[TW-1:0];
            dasq_pkg::CSR_ARM_HOLD_TICKS:    arm_hold_ticks_ff    <= csr_wdata[HW-1:0];
            dasq_pkg::CSR_SPEED_CUT_LIMIT:   speed_cut_limit_ff   <= csr_wdata[SW-1:0];
            dasq_pkg::CSR_RAMP_UP_STEP:      ramp_up_step_ff      <= csr_wdata[SW-1:0];
            dasq_pkg::CSR_RAMP_DOWN_STEP:    ramp_down_step_ff    <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_take) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_data_ff <= req_data;
      end
      if (s2_take) begin
         s2_mapped_ff       <= mapped;
         s2_arm_pulse_ff    <= s1_data_ff.arm_pulse;
         s2_prearm_pulse_ff <= s1_data_ff.prearm_pulse;
      end
      if (s2_fire) begin
         out_data_ff.drive_level     <= drive_in[dasq_pkg::LEVEL_W-1:0];
         out_data_ff.drive_updated   <= updated;
         out_data_ff.mode_now        <= mode_in;
         out_data_ff.activation_line <= act_in;
      end
   end

   // Speed compares against the cut limit and the drive ceiling
   always_comb begin
      mapped_x  = dasq_pkg::CMP_W'(s2_mapped_ff);
      cut_x     = $signed(dasq_pkg::CMP_W'(speed_cut_limit_ff));
      below_cut = (mapped_x < cut_x);
      if (mapped_x < 0) begin
         setpoint = '0;
      end else if (mapped_x > $signed(dasq_pkg::CMP_W'(dasq_pkg::SPEED_MAX))) begin
         setpoint = DW'(dasq_pkg::SPEED_MAX);
      end else begin
         setpoint = DW'(s2_mapped_ff);
      end
   end

   // One tick of the sequencer
   always_comb begin
      mode_in           = mode_ff;
      prearm_on_in      = prearm_on_ff;
      arm_on_in         = arm_on_ff;
      prearm_on_cnt_in  = prearm_on_cnt_ff;
      prearm_off_cnt_in = prearm_off_cnt_ff;
      arm_on_cnt_in     = arm_on_cnt_ff;
      arm_off_cnt_in    = arm_off_cnt_ff;
      ticks_left_in     = ticks_left_ff;
      drive_in          = drive_ff;
      act_in            = act_ff;
      updated           = 1'b1;
      run_arm           = 1'b0;

      // Debounce the prearm switch
      if (s2_prearm_pulse_ff > prearm_threshold_ff) begin
         prearm_off_cnt_in = prearm_hold_ticks_ff;
         if (prearm_on_cnt_ff != '0) begin
            prearm_on_cnt_in = prearm_on_cnt_ff - 1'b1;
         end else begin
            prearm_on_in = 1'b1;
         end
      end else begin
         prearm_on_cnt_in = prearm_hold_ticks_ff;
         if (prearm_off_cnt_ff != '0) begin
            prearm_off_cnt_in = prearm_off_cnt_ff - 1'b1;
         end else begin
            prearm_on_in = 1'b0;
         end
      end

      case (mode_ff)
         dasq_pkg::MODE_DISARMED: begin
            arm_on_in = 1'b0;
            if (prearm_on_in) begin
               // entering prearm holds the drive for this tick
               mode_in = dasq_pkg::MODE_PREARMED;
               updated = 1'b0;
            end else begin
               drive_in = ramp_to('0, drive_ff, ramp_up_step_ff, ramp_down_step_ff);
            end
         end
         dasq_pkg::MODE_PREARMED: begin
            drive_in = ramp_to('0, drive_ff, ramp_up_step_ff, ramp_down_step_ff);
            if (!prearm_on_in) begin
               mode_in = dasq_pkg::MODE_DISARMED;
            end else if (arm_on_ff) begin
               mode_in = dasq_pkg::MODE_ARMED;
            end else begin
               run_arm = 1'b1;
            end
         end
         dasq_pkg::MODE_ARMED: begin
            if (!prearm_on_in) begin
               drive_in = ramp_to('0, drive_ff, ramp_up_step_ff, ramp_down_step_ff);
               mode_in  = dasq_pkg::MODE_DISARMED;
            end else if (!arm_on_ff) begin
               drive_in = ramp_to('0, drive_ff, ramp_up_step_ff, ramp_down_step_ff);
               mode_in  = dasq_pkg::MODE_PREARMED;
            end else begin
               run_arm  = 1'b1;
               drive_in = ramp_to(below_cut ? '0 : setpoint, drive_ff,
                                  ramp_up_step_ff, ramp_down_step_ff);
            end
         end
         default: begin
            mode_in = dasq_pkg::MODE_DISARMED;
         end
      endcase

      // Debounce the arm switch with hysteresis; run the activation one-shot
      if (run_arm) begin
         if (s2_arm_pulse_ff > arm_on_threshold_ff && below_cut) begin
            arm_off_cnt_in = arm_hold_ticks_ff;
            if (arm_on_cnt_ff != '0) begin
               arm_on_cnt_in = arm_on_cnt_ff - 1'b1;
            end else begin
               arm_on_in = 1'b1;
            end
         end else if (s2_arm_pulse_ff < arm_off_threshold_ff) begin
            arm_on_cnt_in = arm_hold_ticks_ff;
            act_in        = 1'b0;
            if (arm_off_cnt_ff != '0) begin
               arm_off_cnt_in = arm_off_cnt_ff - 1'b1;
            end else begin
               arm_on_in = 1'b0;
            end
         end else begin
            arm_off_cnt_in = arm_hold_ticks_ff;
            arm_on_cnt_in  = arm_hold_ticks_ff;
         end

         if (arm_on_in) begin
            if (ticks_left_ff != '0) begin
               ticks_left_in = ticks_left_ff - 1'b1;
               act_in        = 1'b1;
            end else begin
               act_in = 1'b0;
            end
         end else begin
            ticks_left_in = HW'(dasq_pkg::ACTIVATION_TICKS);
            act_in        = 1'b0;
         end
      end
   end

   // Commit the state when a transaction moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= dasq_pkg::MODE_DISARMED;
         prearm_on_ff      <= 1'b0;
         arm_on_ff         <= 1'b0;
         prearm_on_cnt_ff  <= '0;
         prearm_off_cnt_ff <= '0;
         arm_on_cnt_ff     <= '0;
         arm_off_cnt_ff    <= '0;
         ticks_left_ff     <= '0;
         drive_ff          <= '0;
         act_ff            <= 1'b0;
      end else if (s2_fire) begin
         mode_ff           <= mode_in;
         prearm_on_ff      <= prearm_on_in;
         arm_on_ff         <= arm_on_in;
         prearm_on_cnt_ff  <= prearm_on_cnt_in;
         prearm_off_cnt_ff <= prearm_off_cnt_in;
         arm_on_cnt_ff     <= arm_on_cnt_in;
         arm_off_cnt_ff    <= arm_off_cnt_in;
         ticks_left_ff     <= ticks_left_in;
         drive_ff          <= drive_in;
         act_ff            <= act_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import dasq_pkg::*;

   // Receiver hold-off used to back the pipeline up into the request side
   localparam int LONG_HOLD   = 300;
   // Cycles without any accepted transaction before the run is declared hung
   localparam int STALL_LIMIT = 2000;

   // One full set of tuning register values, in register order
   typedef struct packed {
      logic [CSR_DATA_W-1:0] prearm_thr;
      logic [CSR_DATA_W-1:0] prearm_hold;
      logic [CSR_DATA_W-1:0] arm_on_thr;
      logic [CSR_DATA_W-1:0] arm_off_thr;
      logic [CSR_DATA_W-1:0] arm_hold;
      logic [CSR_DATA_W-1:0] cut_limit;
      logic [CSR_DATA_W-1:0] up_step;
      logic [CSR_DATA_W-1:0] down_step;
   } tuning_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   debounced_arming_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Sequencer predictor: tuning registers as the block holds them after
   // masking, plus the debounce / mode / ramp state. Starts at reset values.
   // ------------------------------------------------------------------
   logic [THRESH_W-1:0]    cfg_pre_thr     = 12'd1500;
   logic [HOLD_W-1:0]      cfg_pre_hold    = 16'd10;
   logic [THRESH_W-1:0]    cfg_arm_on_thr  = 12'd1700;
   logic [THRESH_W-1:0]    cfg_arm_off_thr = 12'd1300;
   logic [HOLD_W-1:0]      cfg_arm_hold    = 16'd10;
   logic [SPEED_CFG_W-1:0] cfg_cut         = 10'd50;
   logic [SPEED_CFG_W-1:0] cfg_up          = 10'd5;
   logic [SPEED_CFG_W-1:0] cfg_down        = 10'd10;

   logic [MODE_W-1:0] seq_mode     = MODE_DISARMED;
   logic              sw_prearm    = 1'b0;
   logic              sw_arm       = 1'b0;
   logic [HOLD_W-1:0] pre_rise_cnt = '0;
   logic [HOLD_W-1:0] pre_fall_cnt = '0;
   logic [HOLD_W-1:0] arm_rise_cnt = '0;
   logic [HOLD_W-1:0] arm_fall_cnt = '0;
   logic [HOLD_W-1:0] act_left     = '0;
   logic              act_level    = 1'b0;
   int                drive_acc    = 0;

   // Responses still owed by the block, oldest first
   rsp_type drive_expect_q[$];

   bit gaps_on = 1'b1;
   int hold_tag = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int ticks_sent = 0;
   int rsp_checked = 0;
   int rsp_armed = 0;
   int rsp_active = 0;
   int rsp_held = 0;
   int settings_applied = 0;
   int mismatches = 0;

   // Linear speed map; division truncates toward zero like the hardware
   function automatic longint mapped_speed(logic [PULSE_W-1:0] pulse);
      longint den;
      den = PULSE_MAX - PULSE_MIN;
      if (den == 0) return 0;
      return (longint'(pulse) - PULSE_MIN) * SPEED_MAX / den;
   endfunction

   // Step toward target without passing it; a zero step holds the drive
   function automatic void ramp_drive(int target);
      if (target > drive_acc) begin
         if (target - drive_acc <= int'(cfg_up)) drive_acc = target;
         else drive_acc += int'(cfg_up);
      end else if (target < drive_acc) begin
         if (drive_acc - target <= int'(cfg_down)) drive_acc = target;
         else drive_acc -= int'(cfg_down);
      end
   endfunction

   function automatic void filter_prearm(logic [PULSE_W-1:0] pulse);
      if (pulse > cfg_pre_thr) begin
         pre_fall_cnt = cfg_pre_hold;
         if (pre_rise_cnt != 0) pre_rise_cnt--;
         else sw_prearm = 1'b1;
      end else begin
         pre_rise_cnt = cfg_pre_hold;
         if (pre_fall_cnt != 0) pre_fall_cnt--;
         else sw_prearm = 1'b0;
      end
   endfunction

   // Arm switch with hysteresis band; also runs the activation one-shot
   function automatic void filter_arm(logic [PULSE_W-1:0] pulse, longint speed);
      if (pulse > cfg_arm_on_thr && speed < longint'(cfg_cut)) begin
         arm_fall_cnt = cfg_arm_hold;
         if (arm_rise_cnt != 0) arm_rise_cnt--;
         else sw_arm = 1'b1;
      end else if (pulse < cfg_arm_off_thr) begin
         arm_rise_cnt = cfg_arm_hold;
         act_level = 1'b0;
         if (arm_fall_cnt != 0) arm_fall_cnt--;
         else sw_arm = 1'b0;
      end else begin
         arm_fall_cnt = cfg_arm_hold;
         arm_rise_cnt = cfg_arm_hold;
      end
      if (sw_arm) begin
         if (act_left != 0) begin
            act_left--;
            act_level = 1'b1;
         end else begin
            act_level = 1'b0;
         end
      end else begin
         act_left = HOLD_W'(ACTIVATION_TICKS);
         act_level = 1'b0;
      end
   endfunction

   // Advance the predictor by one control tick and return the response
   function automatic rsp_type predict_tick(req_type t);
      longint  speed;
      longint  setpoint;
      logic    ran;
      rsp_type r;
      speed = mapped_speed(t.speed_pulse);
      ran = 1'b1;
      filter_prearm(t.prearm_pulse);
      case (seq_mode)
         MODE_DISARMED: begin
            sw_arm = 1'b0;
            // Entering prearm skips the ramp for this tick
            if (sw_prearm) begin
               seq_mode = MODE_PREARMED;
               ran = 1'b0;
            end else begin
               ramp_drive(0);
            end
         end
         MODE_PREARMED: begin
            ramp_drive(0);
            if (!sw_prearm) seq_mode = MODE_DISARMED;
            else if (sw_arm) seq_mode = MODE_ARMED;
            else filter_arm(t.arm_pulse, speed);
         end
         default: begin
            if (!sw_prearm) begin
               ramp_drive(0);
               seq_mode = MODE_DISARMED;
            end else if (!sw_arm) begin
               ramp_drive(0);
               seq_mode = MODE_PREARMED;
            end else begin
               filter_arm(t.arm_pulse, speed);
               // Cut compare uses the raw (possibly negative) mapped speed
               if (speed < longint'(cfg_cut)) begin
                  ramp_drive(0);
               end else begin
                  setpoint = speed;
                  if (setpoint < 0) setpoint = 0;
                  if (setpoint > SPEED_MAX) setpoint = SPEED_MAX;
                  ramp_drive(int'(setpoint));
               end
            end
         end
      endcase
      r.drive_level     = LEVEL_W'(drive_acc);
      r.drive_updated   = ran;
      r.mode_now        = seq_mode;
      r.activation_line = act_level;
      return r;
   endfunction

   // Mirror a register write, masked to the register's width
   function automatic void record_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_PREARM_THRESHOLD:  cfg_pre_thr     = val[THRESH_W-1:0];
         CSR_PREARM_HOLD_TICKS: cfg_pre_hold    = val[HOLD_W-1:0];
         CSR_ARM_ON_THRESHOLD:  cfg_arm_on_thr  = val[THRESH_W-1:0];
         CSR_ARM_OFF_THRESHOLD: cfg_arm_off_thr = val[THRESH_W-1:0];
         CSR_ARM_HOLD_TICKS:    cfg_arm_hold    = val[HOLD_W-1:0];
         CSR_SPEED_CUT_LIMIT:   cfg_cut         = val[SPEED_CFG_W-1:0];
         CSR_RAMP_UP_STEP:      cfg_up          = val[SPEED_CFG_W-1:0];
         CSR_RAMP_DOWN_STEP:    cfg_down        = val[SPEED_CFG_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one tick; hold valid and payload until accepted, then predict.
   // Valid is dropped only when a gap is taken, so back-to-back ticks keep
   // it high with a single assignment per edge.
   task automatic send_tick(input logic [PULSE_W-1:0] spd, input logic [PULSE_W-1:0] arm,
                            input logic [PULSE_W-1:0] pre);
      req_type item;
      item.speed_pulse  = spd;
      item.arm_pulse    = arm;
      item.prearm_pulse = pre;
      while (gaps_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      drive_expect_q.push_back(predict_tick(item));
      ticks_sent++;
   endtask

   // Occasionally replace one channel with a random glitch value
   task automatic send_noisy(input int spd, input int arm, input int pre);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) spd = $urandom_range(4095);
      else if (roll < 6) arm = $urandom_range(4095);
      else if (roll < 8) pre = $urandom_range(4095);
      send_tick(PULSE_W'(spd), PULSE_W'(arm), PULSE_W'(pre));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_tick(PULSE_W'($urandom_range(4095)), PULSE_W'($urandom_range(4095)),
                               PULSE_W'($urandom_range(4095)));
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      record_reg(idx, val);
   endtask

   // Write all eight registers back to back; call only with the block idle
   task automatic apply_tuning(input tuning_type s);
      write_reg(CSR_PREARM_THRESHOLD, s.prearm_thr);
      write_reg(CSR_PREARM_HOLD_TICKS, s.prearm_hold);
      write_reg(CSR_ARM_ON_THRESHOLD, s.arm_on_thr);
      write_reg(CSR_ARM_OFF_THRESHOLD, s.arm_off_thr);
      write_reg(CSR_ARM_HOLD_TICKS, s.arm_hold);
      write_reg(CSR_SPEED_CUT_LIMIT, s.cut_limit);
      write_reg(CSR_RAMP_UP_STEP, s.up_step);
      write_reg(CSR_RAMP_DOWN_STEP, s.down_step);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // Set random bits above the register width to exercise masking
   function automatic logic [CSR_DATA_W-1:0] junk_above(int v, int w);
      logic [CSR_DATA_W-1:0] r;
      r = CSR_DATA_W'(v);
      if ($urandom_range(3) == 0) r = r | CSR_DATA_W'($urandom << w);
      return r;
   endfunction

   function automatic int pick_step();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 0;
      if (roll < 6) return $urandom_range(1, 60);
      return $urandom_range(61, 1023);
   endfunction

   // Short holds and thresholds near nominal so that episodes reach armed
   function automatic tuning_type random_tuning();
      tuning_type s;
      s.prearm_thr  = junk_above($urandom_range(1200, 1800), THRESH_W);
      s.prearm_hold = junk_above($urandom_range(0, 6), HOLD_W);
      s.arm_on_thr  = junk_above($urandom_range(1500, 1900), THRESH_W);
      s.arm_off_thr = junk_above($urandom_range(1100, 1600), THRESH_W);
      s.arm_hold    = junk_above($urandom_range(0, 6), HOLD_W);
      s.cut_limit   = junk_above(($urandom_range(3) == 0) ? $urandom_range(1023) :
                                 $urandom_range(150), SPEED_CFG_W);
      s.up_step     = junk_above(pick_step(), SPEED_CFG_W);
      s.down_step   = junk_above(pick_step(), SPEED_CFG_W);
      return s;
   endfunction

   // Pulse generators relative to the current thresholds; half of them
   // land close to the threshold edge
   function automatic int pick_above(int thr);
      if (thr >= 4095) return 4095;
      if ($urandom_range(1)) return $urandom_range(thr + 1, (thr + 80 > 4095) ? 4095 : thr + 80);
      return $urandom_range(thr + 1, 4095);
   endfunction

   function automatic int pick_below(int thr);
      if (thr == 0) return 0;
      if ($urandom_range(1)) return $urandom_range((thr > 80) ? thr - 80 : 0, thr - 1);
      return $urandom_range(0, thr - 1);
   endfunction

   // Speed pulse whose mapped value stays under the cut limit
   function automatic int low_speed();
      int top;
      top = int'(PULSE_MIN) - 1 + int'(cfg_cut);
      if (top > 4095) top = 4095;
      if ($urandom_range(9) < 7) return $urandom_range((top > 100) ? top - 100 : 0, top);
      return $urandom_range(0, top);
   endfunction

   function automatic int run_speed();
      if ($urandom_range(3) != 0) return $urandom_range(int'(PULSE_MIN) - 30, int'(PULSE_MAX) + 30);
      return $urandom_range(4095);
   endfunction

   function automatic int span(int hold);
      if (hold > 30) return $urandom_range(1, 30);
      return hold + $urandom_range(1, 4);
   endfunction

   // One arming session: prearm, arm at low speed, run, maybe disarm the
   // arm switch, then drop prearm. Content is random, structure is legal.
   task automatic run_episode();
      int n;
      n = span(cfg_pre_hold);
      repeat (n) send_noisy(low_speed(), pick_below(cfg_arm_off_thr), pick_above(cfg_pre_thr));
      n = span(cfg_arm_hold) + 2;
      repeat (n) send_noisy(low_speed(), pick_above(cfg_arm_on_thr), pick_above(cfg_pre_thr));
      n = $urandom_range(5, 40);
      repeat (n) send_noisy(run_speed(), $urandom_range(int'(cfg_arm_off_thr), 4095),
                            pick_above(cfg_pre_thr));
      if ($urandom_range(1)) begin
         n = span(cfg_arm_hold) + 1;
         repeat (n) send_noisy(run_speed(), pick_below(cfg_arm_off_thr), pick_above(cfg_pre_thr));
      end
      n = span(cfg_pre_hold) + 1;
      repeat (n) send_noisy(run_speed(), pick_below(cfg_arm_off_thr),
                            $urandom_range(0, int'(cfg_pre_thr)));
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Ready with random stalls; a bump of hold_tag starts a long hold-off
   // counted here, so the pipeline fills and req_ready must drop.
   always @(posedge clock) begin
      if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 29);
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expect_q.size() == 0) begin
            $error("response with no tick outstanding: %h", rsp_data);
            mismatches++;
         end else begin
            want = drive_expect_q.pop_front();
            rsp_checked++;
            if (rsp_data.drive_level !== want.drive_level) begin
               $error("drive_level: expected %0d, got %0d", want.drive_level,
                      rsp_data.drive_level);
               mismatches++;
            end
            if (rsp_data.drive_updated !== want.drive_updated) begin
               $error("drive_updated: expected %0d, got %0d", want.drive_updated,
                      rsp_data.drive_updated);
               mismatches++;
            end
            if (rsp_data.mode_now !== want.mode_now) begin
               $error("mode_now: expected %0d, got %0d", want.mode_now, rsp_data.mode_now);
               mismatches++;
            end
            if (rsp_data.activation_line !== want.activation_line) begin
               $error("activation_line: expected %0d, got %0d", want.activation_line,
                      rsp_data.activation_line);
               mismatches++;
            end
            if (want.mode_now == MODE_ARMED) rsp_armed++;
            if (want.activation_line) rsp_active++;
            if (!want.drive_updated) rsp_held++;
         end
      end
   end

   // Hang detector: any accepted transaction on either side resets it
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // All-zero and all-ones pulses under reset defaults
   task automatic test_field_extremes();
      send_tick('0, '0, '0);
      send_tick('1, '1, '1);
      send_tick('0, '1, '0);
      send_tick('1, '0, '1);
      drain();
   endtask

   // Walk through prearm, arm, run with speed out of range on both sides,
   // arm drop, re-arm with the activation one-shot, and finish armed at
   // full drive so the next test starts from a nonzero drive.
   task automatic test_arming_walk();
      tuning_type s;
      s = '{prearm_thr: 16'd1500, prearm_hold: 16'd1, arm_on_thr: 16'd1700,
            arm_off_thr: 16'd1300, arm_hold: 16'd1, cut_limit: 16'd50,
            up_step: 16'd400, down_step: 16'd300};
      apply_tuning(s);
      repeat (2) send_tick(12'd1000, 12'd1000, 12'd1800);  // disarmed to prearmed
      repeat (3) send_tick(12'd1020, 12'd1900, 12'd1800);  // arm at low speed
      repeat (4) send_tick(12'd4095, 12'd1500, 12'd1800);  // mapped above max: clamp
      repeat (2) send_tick(12'd0, 12'd1500, 12'd1800);     // mapped negative: cut
      repeat (3) send_tick(12'd1500, 12'd1000, 12'd1800);  // arm switch off
      repeat (4) send_tick(12'd1010, 12'd1900, 12'd1800);  // re-arm, one-shot fires
      repeat (3) send_tick(12'd2000, 12'd1500, 12'd1800);  // ramp to full drive
      drain();
   endtask

   // Every register at zero (zero ramp steps hold the drive), then every
   // register with all bits written
   task automatic test_extreme_settings();
      apply_tuning('0);
      send_random(40);
      run_episode();
      drain();
      apply_tuning('1);
      send_random(40);
      run_episode();
      drain();
   endtask

   // Mostly legal arming sessions over several random settings; one
   // setting runs with no gaps on either side
   task automatic test_random_sequences();
      for (int k = 0; k < 6; k++) begin
         apply_tuning(random_tuning());
         gaps_on = (k != 3);
         repeat (4) run_episode();
         send_random(40);
         drain();
      end
      gaps_on = 1'b1;
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_backpressure();
      apply_tuning(random_tuning());
      hold_tag <= hold_tag + 1;
      repeat (2) run_episode();
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_arming_walk();
      test_extreme_settings();
      test_random_sequences();
      test_backpressure();
      $display("Sent %0d ticks under %0d register settings; checked %0d responses.",
               ticks_sent, settings_applied, rsp_checked);
      $display("Armed in %0d responses, activation high in %0d, ramp skipped in %0d.",
               rsp_armed, rsp_active, rsp_held);
      if (mismatches == 0 && drive_expect_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/dasq_pkg.sv
hw/rtl/dasq_speed_map.sv
hw/rtl/debounced_arming_sequencer_core.sv
tb/tb_top.sv
